// ===== rtl/recency_stamped_key_table_defines.svh =====
// Assertion macros shared by the key table RTL.
`ifndef RECENCY_STAMPED_KEY_TABLE_DEFINES_SVH
`define RECENCY_STAMPED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSKT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSKT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rskt_pkg.sv =====
package rskt_pkg;

   localparam int SLOTS      = 16;
   localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int KEY_W      = 32;
   localparam int STAMP_W    = 32;
   localparam int EVICT_W    = 32;
   localparam int KNOWN_W    = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   localparam logic OP_NOTE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key_high;
      logic [KEY_W-1:0]   key_low;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

// ===== rtl/rskt_ram.sv =====
module rskt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/recency_stamped_key_table.sv =====
// Flow: an accepted note or query scans the occupied slots, one slot read per cycle, and each
// read word is compared once registered; the finish state then registers the result word.
// Ignored notes (zero key or repeat of the last note) skip the scan.
// A new word is accepted only in the idle state, so not while a word is in progress; the
// finish state waits while the output register still holds an untaken word.
// Reset (synchronous, active high) empties the table and sets the stamp counter to 1.
`include "recency_stamped_key_table_defines.svh"

module recency_stamped_key_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key_high [31:0], key_low [63:32]
   input  logic [rskt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // changed [0], stamp [32:1], known_count [37:33], eviction_count [69:38], zero [71:70]
   output logic [rskt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import rskt_pkg::*;

   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     key_high_ff, key_high_in;
   logic [KEY_W-1:0]     key_low_ff, key_low_in;
   logic                 ignore_ff, ignore_in;
   logic [KEY_W-1:0]     last_high_ff, last_high_in;
   logic [KEY_W-1:0]     last_low_ff, last_low_in;
   logic                 last_valid_ff, last_valid_in;
   logic [CNT_W-1:0]     occupied_ff, occupied_in;
   logic [STAMP_W-1:0]   next_stamp_ff, next_stamp_in;
   logic [EVICT_W-1:0]   evictions_ff, evictions_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [STAMP_W-1:0]   hit_stamp_ff, hit_stamp_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0]   min_stamp_ff, min_stamp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 finish_go;
   logic                 full;
   logic                 is_note;
   logic [KEY_W-1:0]     in_high;
   logic [KEY_W-1:0]     in_low;
   logic                 in_ignore;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_entry;
   logic                 ram_rd_en;
   logic [ENTRY_W-1:0]   ram_rd_data;
   entry_type            rd_entry;
   logic                 rd_match;
   logic                 res_changed;
   logic [STAMP_W-1:0]   res_stamp;
   logic [31:0]          occ_wide;

   rskt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish_go  = (state_ff == ST_FINISH) && out_free;
   assign full       = (occupied_ff == CNT_W'(SLOTS));
   assign in_high    = req_tdata[KEY_W-1:0];
   assign in_low     = req_tdata[2*KEY_W-1:KEY_W];
   assign is_note    = (req_tuser == OP_NOTE);
   assign in_ignore  = is_note && (((in_high == '0) && (in_low == '0)) ||
                       (last_valid_ff && (last_high_ff == in_high) &&
                        (last_low_ff == in_low)));

   assign ram_rd_en  = (state_ff == ST_SCAN) && (issue_ff < occupied_ff);
   assign rd_entry   = entry_type'(ram_rd_data);
   assign rd_match   = (rd_entry.key_high == key_high_ff) && (rd_entry.key_low == key_low_ff);

   // Existing key keeps its slot; a new key fills the next free slot or the oldest one.
   always_comb begin
      priority if (hit_ff) begin
         ram_wr_addr = hit_idx_ff;
      end else if (!full) begin
         ram_wr_addr = occupied_ff[IDX_W-1:0];
      end else begin
         ram_wr_addr = min_idx_ff;
      end
   end

   assign ram_wr_en             = finish_go && (op_ff == OP_NOTE) && !ignore_ff;
   assign ram_wr_entry.key_high = key_high_ff;
   assign ram_wr_entry.key_low  = key_low_ff;
   assign ram_wr_entry.stamp    = next_stamp_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_high_in   = key_high_ff;
      key_low_in    = key_low_ff;
      ignore_in     = ignore_ff;
      last_high_in  = last_high_ff;
      last_low_in   = last_low_ff;
      last_valid_in = last_valid_ff;
      occupied_in   = occupied_ff;
      next_stamp_in = next_stamp_ff;
      evictions_in  = evictions_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_stamp_in  = hit_stamp_ff;
      min_idx_in    = min_idx_ff;
      min_stamp_in  = min_stamp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      res_changed   = 1'b0;
      res_stamp     = '0;
      occ_wide      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_tuser;
               key_high_in = in_high;
               key_low_in  = in_low;
               ignore_in   = in_ignore;
               issue_in    = '0;
               hit_in      = 1'b0;
               if (is_note && !in_ignore) begin
                  last_high_in  = in_high;
                  last_low_in   = in_low;
                  last_valid_in = 1'b1;
               end
               state_in = in_ignore ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               issue_in    = issue_ff + CNT_W'(1);
               cmp_idx_in  = issue_ff[IDX_W-1:0];
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) begin
               if (rd_match && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
                  hit_stamp_in = rd_entry.stamp;
               end
               // Strict compare keeps the lowest index on equal stamps.
               if ((cmp_idx_ff == '0) || (rd_entry.stamp < min_stamp_ff)) begin
                  min_idx_in   = cmp_idx_ff;
                  min_stamp_in = rd_entry.stamp;
               end
            end
            if ((issue_ff == occupied_ff) && !rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (op_ff == OP_QUERY) begin
                  res_stamp = hit_ff ? hit_stamp_ff : '0;
               end else if (!ignore_ff) begin
                  res_changed = 1'b1;
                  res_stamp   = next_stamp_ff;
                  next_stamp_in = (next_stamp_ff == '1) ? STAMP_W'(1)
                                                        : next_stamp_ff + STAMP_W'(1);
                  if (!hit_ff) begin
                     if (full) begin
                        evictions_in = evictions_ff + EVICT_W'(1);
                     end else begin
                        occupied_in = occupied_ff + CNT_W'(1);
                     end
                  end
               end
               occ_wide     = 32'(occupied_in);
               rsp_data_in  = {2'b00, evictions_in, occ_wide[KNOWN_W-1:0], res_stamp,
                               res_changed};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_high_ff  <= '0;
         last_low_ff   <= '0;
         last_valid_ff <= 1'b0;
         occupied_ff   <= '0;
         next_stamp_ff <= STAMP_W'(1);
         evictions_ff  <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_high_ff  <= last_high_in;
         last_low_ff   <= last_low_in;
         last_valid_ff <= last_valid_in;
         occupied_ff   <= occupied_in;
         next_stamp_ff <= next_stamp_in;
         evictions_ff  <= evictions_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_high_ff  <= key_high_in;
      key_low_ff   <= key_low_in;
      ignore_ff    <= ignore_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_stamp_ff <= hit_stamp_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RSKT_ASSERT_NOW(a_occ_bound, 1'b1, occupied_ff <= CNT_W'(SLOTS),
      "occupied count above table size")
   `RSKT_ASSERT_NOW(a_stamp_nonzero, 1'b1, next_stamp_ff != '0,
      "stamp counter reached zero")
   `RSKT_ASSERT_NOW(a_evict_full, evictions_in != evictions_ff, full && !hit_ff,
      "eviction counted while table not full or key present")
   `RSKT_ASSERT_NOW(a_no_rd_wr_overlap, ram_wr_en, !ram_rd_en && !rd_valid_ff,
      "slot write overlaps the scan")
   `RSKT_ASSERT_NEXT(a_result_lost, rsp_valid_ff && !rsp_tready,
      rsp_valid_ff && $stable(rsp_data_ff), "pending result word changed")

endmodule
